// ===== design/pgmc_pkg.sv =====
// shared constants, types and constant tables of the pixel gamut matrix correction pipeline
`timescale 1ns / 1ps

package pgmc_pkg;

   // channel code, coefficient and encode index sizing
   localparam int CHANNEL_BITS      = 5;
   localparam int COEFF_FRAC_BITS   = 14;
   localparam int ENCODE_INDEX_BITS = 12;

   localparam int PIXEL_BITS = 32;
   localparam int BYTE_BITS  = 8;
   localparam int COEFF_BITS = 18;
   localparam int ROW_BITS   = 3 * COEFF_BITS;
   localparam int CSR_INDEX_BITS = 2;

   // linear Q1.15 levels run 0..32768
   localparam int LIN_BITS = 16;
   localparam logic [LIN_BITS-1:0] ONE_Q15 = LIN_BITS'(32768);
   localparam int Q15_HALF = 16384;

   // matrix datapath widths
   localparam int PROD_BITS = COEFF_BITS + LIN_BITS + 1;
   localparam int ACC_BITS  = PROD_BITS + 2;
   localparam int ROUND_HALF = 1 << (COEFF_FRAC_BITS - 1);
   localparam logic [COEFF_BITS-1:0] COEFF_ONE = COEFF_BITS'(1 << COEFF_FRAC_BITS);

   // table geometry
   localparam int DEC_ENTRIES = 1 << CHANNEL_BITS;
   localparam int DEC_MAX     = DEC_ENTRIES - 1;
   localparam int ENC_D       = (1 << ENCODE_INDEX_BITS) - 1;
   localparam int ENC_LEVELS  = 1 << BYTE_BITS;

   // srgb encode constants, scaled to integers (255 folded in)
   localparam longint unsigned LIN_LIMIT_NUM    = 31308;
   localparam longint unsigned LIN_LIMIT_DEN    = 10000000;
   localparam longint unsigned LIN_SLOPE_TENTHS = 32946;
   localparam int ENC_GAIN_MILLI   = 269025;
   localparam int ENC_OFFSET_MILLI = 13525;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENABLE      = 2'd0,
      CSR_COEFF_RED   = 2'd1,
      CSR_COEFF_GREEN = 2'd2,
      CSR_COEFF_BLUE  = 2'd3
   } pgmc_csr_index_type;

   // channel payloads
   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_in;
      logic                  frame_end_in;
   } pgmc_req_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_out;
      logic                  frame_end_out;
   } pgmc_rsp_type;

   // stage load enables into the datapath parts
   typedef struct packed {
      logic mul_load;
      logic sum_load;
      logic clamp_load;
   } pgmc_matrix_ctl_type;

   typedef struct packed {
      logic index_load;
      logic search_load;
      logic out_load;
   } pgmc_encode_ctl_type;

   // wide integers for exact table construction at elaboration
   localparam int BIG_BITS = 320;
   typedef logic [BIG_BITS-1:0] pgmc_big_type;

   typedef logic [DEC_ENTRIES-1:0][LIN_BITS-1:0]          pgmc_dec_tab_type;
   typedef logic [ENC_LEVELS-1:0][ENCODE_INDEX_BITS-1:0] pgmc_thr_tab_type;

   function automatic pgmc_big_type big_pow(input pgmc_big_type base, input int times);
      pgmc_big_type acc;
      acc = pgmc_big_type'(1);
      for (int n = 0; n < times; n++) begin
         acc = acc * base;
      end
      return acc;
   endfunction

   // largest t in 0..32768 with 32768*(i/M)^2.2 + 1/2 >= t
   function automatic logic [LIN_BITS-1:0] decode_entry(input int i);
      pgmc_big_type lhs;
      pgmc_big_type rhs;
      pgmc_big_type m_pow;
      int lo;
      int hi;
      int mid;
      lhs   = big_pow(pgmc_big_type'(i), 11) << 80;
      m_pow = big_pow(pgmc_big_type'(DEC_MAX), 11);
      lo    = 0;
      hi    = 32768;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         rhs = big_pow(pgmc_big_type'(2 * mid - 1), 5) * m_pow;
         if (lhs >= rhs) lo = mid;
         else hi = mid - 1;
      end
      return LIN_BITS'(lo);
   endfunction

   function automatic pgmc_dec_tab_type build_dec_tab();
      pgmc_dec_tab_type tab;
      for (int i = 0; i < DEC_ENTRIES; i++) begin
         tab[i] = decode_entry(i);
      end
      return tab;
   endfunction

   localparam pgmc_big_type ENC_GAIN_POW = big_pow(pgmc_big_type'(ENC_GAIN_MILLI), 12);
   localparam pgmc_big_type ENC_D_POW    = big_pow(pgmc_big_type'(ENC_D), 5);

   // true when the encoded byte of index j reaches k
   function automatic logic enc_reaches(input int j, input int k);
      longint unsigned jl;
      longint unsigned dl;
      longint unsigned kl;
      jl = longint'(j);
      dl = longint'(ENC_D);
      kl = longint'(k);
      if (jl * LIN_LIMIT_DEN <= LIN_LIMIT_NUM * dl) begin
         return (LIN_SLOPE_TENTHS * jl + 5 * dl) >= (10 * dl * kl);
      end
      return (big_pow(pgmc_big_type'(j), 5) * ENC_GAIN_POW) >=
             (big_pow(pgmc_big_type'(1000 * k + ENC_OFFSET_MILLI), 12) * ENC_D_POW);
   endfunction

   // smallest index whose encoded byte reaches each level
   function automatic pgmc_thr_tab_type build_thr_tab();
      pgmc_thr_tab_type tab;
      int lo;
      int hi;
      int mid;
      tab[0] = '0;
      for (int k = 1; k < ENC_LEVELS; k++) begin
         lo = 0;
         hi = ENC_D;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (enc_reaches(mid, k)) hi = mid;
            else lo = mid + 1;
         end
         tab[k] = ENCODE_INDEX_BITS'(lo);
      end
      return tab;
   endfunction

   localparam pgmc_dec_tab_type DECODE_TAB = build_dec_tab();
   localparam pgmc_thr_tab_type ENC_THR    = build_thr_tab();

endpackage

// ===== design/pgmc_matrix.sv =====
// 3x3 matrix multiply, row sums and clamp to the unit range, three pipeline stages
`timescale 1ns / 1ps

module pgmc_matrix
   import pgmc_pkg::*;
(
   input  logic                               clock,
   input  pgmc_matrix_ctl_type                ctl,
   input  logic [2:0][LIN_BITS-1:0]           lin,
   input  logic [2:0][ROW_BITS-1:0]           coeff_row,
   output logic [2:0][LIN_BITS-1:0]           level
);

   logic signed [PROD_BITS-1:0] prod_in [3][3];
   logic signed [PROD_BITS-1:0] prod_ff [3][3];
   logic signed [ACC_BITS-1:0]  acc_in  [3];
   logic signed [ACC_BITS-1:0]  acc_ff  [3];
   logic [2:0][LIN_BITS-1:0]    level_in;
   logic [2:0][LIN_BITS-1:0]    level_ff;

   // nine products, coefficient times linear level
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(coeff_row[r][c*COEFF_BITS +: COEFF_BITS]) *
                            $signed({1'b0, lin[c]});
         end
      end
   end

   // row sums
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc_in[r] = ACC_BITS'(prod_ff[r][0]) + ACC_BITS'(prod_ff[r][1]) +
                     ACC_BITS'(prod_ff[r][2]);
      end
   end

   // round away the fraction and clamp to 0..1.0
   always_comb begin
      logic [ACC_BITS-1:0] rounded;
      logic                positive;
      for (int r = 0; r < 3; r++) begin
         positive = !acc_ff[r][ACC_BITS-1] && (acc_ff[r] != '0);
         rounded  = (ACC_BITS'(unsigned'(acc_ff[r])) + ACC_BITS'(ROUND_HALF)) >>
                    COEFF_FRAC_BITS;
         if (!positive) level_in[r] = '0;
         else if (rounded > ACC_BITS'(ONE_Q15)) level_in[r] = ONE_Q15;
         else level_in[r] = rounded[LIN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_load) begin
         prod_ff <= prod_in;
      end
      if (ctl.sum_load) begin
         acc_ff <= acc_in;
      end
      if (ctl.clamp_load) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

// ===== design/pgmc_encode.sv =====
// srgb encode of one linear level: table index, then a two-stage threshold search
`timescale 1ns / 1ps

module pgmc_encode
   import pgmc_pkg::*;
(
   input  logic                  clock,
   input  pgmc_encode_ctl_type   ctl,
   input  logic [LIN_BITS-1:0]   level,
   output logic [BYTE_BITS-1:0]  code
);

   localparam int SCALE_BITS = LIN_BITS + ENCODE_INDEX_BITS;

   logic [SCALE_BITS-1:0]        scaled;
   logic [ENCODE_INDEX_BITS-1:0] index_in;
   logic [ENCODE_INDEX_BITS-1:0] index_ff;
   logic [ENCODE_INDEX_BITS-1:0] index_hold_ff;
   logic [BYTE_BITS-1:0]         upper_in;
   logic [BYTE_BITS-1:0]         upper_ff;
   logic [BYTE_BITS-1:0]         code_in;
   logic [BYTE_BITS-1:0]         code_ff;

   // index = (level * D + half) >> 15
   assign scaled   = SCALE_BITS'(level) * SCALE_BITS'(ENC_D) + SCALE_BITS'(Q15_HALF);
   assign index_in = scaled[LIN_BITS-1 +: ENCODE_INDEX_BITS];

   // upper four bits of the code: largest level whose threshold is reached
   always_comb begin
      logic [BYTE_BITS-1:0] cand;
      upper_in = '0;
      for (int b = BYTE_BITS - 1; b >= BYTE_BITS / 2; b--) begin
         cand = upper_in | (BYTE_BITS'(1) << b);
         if (ENC_THR[cand] <= index_ff) upper_in = cand;
      end
   end

   // lower four bits
   always_comb begin
      logic [BYTE_BITS-1:0] cand;
      code_in = upper_ff;
      for (int b = BYTE_BITS / 2 - 1; b >= 0; b--) begin
         cand = code_in | (BYTE_BITS'(1) << b);
         if (ENC_THR[cand] <= index_hold_ff) code_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.index_load) begin
         index_ff <= index_in;
      end
      if (ctl.search_load) begin
         upper_ff      <= upper_in;
         index_hold_ff <= index_ff;
      end
      if (ctl.out_load) begin
         code_ff <= code_in;
      end
   end

   assign code = code_ff;

endmodule

// ===== design/pixel_gamut_matrix_correct.sv =====
// top level: gamma decode, color matrix and srgb encode of an argb pixel stream
// pipeline: an accepted item passes through all seven stages before rsp_valid rises for it
// throughput: one item per clock; each stage holds when its successor is full
// and stalled, so bubbles are squeezed out and a stall drops nothing
// reset: clears all stage valid bits, correction off, identity matrix
`timescale 1ns / 1ps

module pixel_gamut_matrix_correct
   import pgmc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  pgmc_req_type               req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output pgmc_rsp_type               rsp_payload,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ROW_BITS-1:0]        csr_wdata
);

   localparam int NUM_STAGES = 7;

   logic                      enable_in;
   logic                      enable_ff;
   logic [2:0][ROW_BITS-1:0]  coeff_row_in;
   logic [2:0][ROW_BITS-1:0]  coeff_row_ff;

   logic [NUM_STAGES+1:1]     ready;
   logic [NUM_STAGES:1]       valid_in;
   logic [NUM_STAGES:1]       valid_ff;
   logic [PIXEL_BITS-1:0]     pix_ff [1:NUM_STAGES];
   logic [NUM_STAGES:1]       frame_end_ff;
   logic [NUM_STAGES:1]       mode_ff;

   logic [2:0][LIN_BITS-1:0]  lin_in;
   logic [2:0][LIN_BITS-1:0]  lin_ff;
   logic [2:0][LIN_BITS-1:0]  level;
   logic [2:0][BYTE_BITS-1:0] code;

   pgmc_matrix_ctl_type       matrix_ctl;
   pgmc_encode_ctl_type       encode_ctl;

   // configuration registers
   always_comb begin
      enable_in    = enable_ff;
      coeff_row_in = coeff_row_ff;
      if (csr_wr_en) begin
         unique case (pgmc_csr_index_type'(csr_index))
            CSR_ENABLE:      enable_in       = csr_wdata[0];
            CSR_COEFF_RED:   coeff_row_in[0] = csr_wdata;
            CSR_COEFF_GREEN: coeff_row_in[1] = csr_wdata;
            CSR_COEFF_BLUE:  coeff_row_in[2] = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b0;
         coeff_row_ff[0] <= ROW_BITS'(COEFF_ONE);
         coeff_row_ff[1] <= ROW_BITS'(COEFF_ONE) << COEFF_BITS;
         coeff_row_ff[2] <= ROW_BITS'(COEFF_ONE) << (2 * COEFF_BITS);
      end else begin
         enable_ff    <= enable_in;
         coeff_row_ff <= coeff_row_in;
      end
   end

   // a stage loads when it is empty or its successor moves on
   always_comb begin
      ready[NUM_STAGES+1] = !rsp_stall;
      for (int s = NUM_STAGES; s >= 1; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
   end

   always_comb begin
      valid_in[1] = ready[1] ? req_valid : valid_ff[1];
      for (int s = 2; s <= NUM_STAGES; s++) begin
         valid_in[s] = ready[s] ? valid_ff[s-1] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // pass-through pixel, frame mark and mode travel with each item
   always_ff @(posedge clock) begin
      if (ready[1]) begin
         pix_ff[1]       <= req_payload.pixel_in;
         frame_end_ff[1] <= req_payload.frame_end_in;
         mode_ff[1]      <= enable_ff;
      end
      for (int s = 2; s <= NUM_STAGES; s++) begin
         if (ready[s]) begin
            pix_ff[s]       <= pix_ff[s-1];
            frame_end_ff[s] <= frame_end_ff[s-1];
            mode_ff[s]      <= mode_ff[s-1];
         end
      end
   end

   // gamma decode of the top channel bits
   assign lin_in[0] = DECODE_TAB[req_payload.pixel_in[24-CHANNEL_BITS +: CHANNEL_BITS]];
   assign lin_in[1] = DECODE_TAB[req_payload.pixel_in[16-CHANNEL_BITS +: CHANNEL_BITS]];
   assign lin_in[2] = DECODE_TAB[req_payload.pixel_in[8-CHANNEL_BITS +: CHANNEL_BITS]];

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         lin_ff <= lin_in;
      end
   end

   // matrix stages 2..4, encode stages 5..7
   assign matrix_ctl.mul_load    = ready[2];
   assign matrix_ctl.sum_load    = ready[3];
   assign matrix_ctl.clamp_load  = ready[4];
   assign encode_ctl.index_load  = ready[5];
   assign encode_ctl.search_load = ready[6];
   assign encode_ctl.out_load    = ready[7];

   pgmc_matrix u_matrix (
      .clock     (clock),
      .ctl       (matrix_ctl),
      .lin       (lin_ff),
      .coeff_row (coeff_row_ff),
      .level     (level)
   );

   for (genvar c = 0; c < 3; c++) begin : g_encode
      pgmc_encode u_encode (
         .clock (clock),
         .ctl   (encode_ctl),
         .level (level[c]),
         .code  (code[c])
      );
   end

   // result item
   assign req_stall = !ready[1];
   assign rsp_valid = valid_ff[NUM_STAGES];
   assign rsp_payload.pixel_out = mode_ff[NUM_STAGES]
      ? {pix_ff[NUM_STAGES][PIXEL_BITS-1 -: BYTE_BITS], code[0], code[1], code[2]}
      : pix_ff[NUM_STAGES];
   assign rsp_payload.frame_end_out = frame_end_ff[NUM_STAGES];

endmodule
